// ----- rtl/ald_pkg.sv -----
package ald_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQR,
    ST_ENV,
    ST_DIV,
    ST_ROOT,
    ST_RMS,
    ST_OUT
  } ald_state_t;

  localparam int unsigned SampleW = 16;
  localparam int unsigned LevelW  = 15;
  localparam int unsigned AlphaW  = 15;
  localparam int unsigned MeanW   = 31;

  localparam logic [LevelW-1:0] LevelMax = 15'h7FFF;
  localparam logic [AlphaW-1:0] EnvAlphaRst = 15'd1024;
  localparam logic [AlphaW-1:0] RmsAlphaRst = 15'd3277;

  localparam logic [0:0] CfgEnvAlpha = 1'b0;
  localparam logic [0:0] CfgRmsAlpha = 1'b1;

endpackage

// ----- rtl/audio_level_detector.sv -----
// A sample is squared by a serial multiplier, then the envelope advances and the
// frame energy accumulates; a frame-closing sample goes on through the divide (one
// quotient bit for each of the 30 + $clog2(MAX_FRAME + 1) energy bits), root, RMS, output load.
// A new sample is accepted only once the previous one is through; a frame-closing
// sample is held longer while the output register is full and stalled.
// Synchronous active-low reset clears the envelope, RMS, peak and energy state and sets coefficient defaults.
module audio_level_detector #(
  parameter int unsigned MAX_FRAME = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [14:0]                  cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           in_sample,
  input  logic                         in_last_in_frame,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [14:0]                  out_frame_peak,
  output logic [14:0]                  out_envelope_level,
  output logic [14:0]                  out_smoothed_rms,
  output logic [30:0]                  out_mean_energy
);
  import ald_pkg::*;

  localparam int unsigned CntW    = $clog2(MAX_FRAME + 1);
  localparam int unsigned EnergyW = 30 + CntW;

  ald_state_t state_r, state_nxt;

  logic [AlphaW-1:0]  env_alpha_r, rms_alpha_r;
  logic [LevelW-1:0]  env_r, rms_r, peak_r, abs_r;
  logic [EnergyW-1:0] esum_r;
  logic [CntW-1:0]    cnt_r;
  logic               last_r;
  logic [5:0]         step_r;
  // serial multiplier: multiplicand, shifting multiplier, product
  logic [15:0]        mcand_r, mplr_r;
  logic [31:0]        prod_r;
  // serial root
  logic [31:0]        rx_r;
  logic [17:0]        rrem_r;
  logic [15:0]        root_r;
  logic [MeanW-1:0]   mean_r;
  // serial divider: dividend shifts out of dq_r, quotient shifts in
  logic [EnergyW-1:0] dq_r, dq_cur;
  logic [CntW:0]      drem_r, drem_cur, dsh, cnt_ext;
  logic               div_first, div_ge;
  logic [MeanW-1:0]   mean_nxt;

  logic               out_valid_r;
  logic [LevelW-1:0]  o_peak_r, o_env_r, o_rms_r;
  logic [MeanW-1:0]   o_mean_r;

  logic               in_acc, out_free, frame_end;
  logic [15:0]        mag_in;
  logic [LevelW-1:0]  abs_in;
  logic [17:0]        rtrial;
  logic [15:0]        root_sat;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  // true magnitude, so a full-scale negative sample squares to 2^30
  assign mag_in   = in_sample[15] ? 16'(-in_sample) : in_sample;
  assign abs_in   = mag_in[15] ? LevelMax : mag_in[14:0];
  assign frame_end = last_r || (32'(cnt_r) >= 32'(MAX_FRAME));
  assign rtrial   = {rrem_r[15:0], rx_r[31:30]} - {root_r, 2'b01};
  assign root_sat = root_r[15] ? 16'h7FFF : root_r;

  // first divide step takes the dividend straight from the energy sum
  assign div_first = (step_r == 6'd0);
  assign dq_cur    = div_first ? esum_r : dq_r;
  assign drem_cur  = div_first ? '0 : drem_r;
  assign cnt_ext   = {1'b0, cnt_r};
  assign dsh       = {drem_cur[CntW-1:0], dq_cur[EnergyW-1]};
  assign div_ge    = (dsh >= cnt_ext);
  assign mean_nxt  = {dq_cur[MeanW-2:0], div_ge};

  // One-pole step: y + floor(alpha*(t-y)/2^15), clamped (no overshoot)
  function automatic logic [LevelW-1:0] one_pole(input logic [LevelW-1:0] y,
      input logic [LevelW-1:0] t, input logic [AlphaW-1:0] a);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [17:0] v;
    d = $signed({2'b00, t}) - $signed({2'b00, y});
    p = $signed({1'b0, a}) * d;
    v = $signed({3'b000, y}) + 18'(p >>> 15);
    if (v < 0) return '0;
    if (v > 18'sd32767) return LevelMax;
    return v[14:0];
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SQR;
      ST_SQR:  if (step_r == 6'd15) state_nxt = ST_ENV;
      ST_ENV:  state_nxt = frame_end ? ST_DIV : ST_IDLE;
      ST_DIV:  if (step_r == 6'(EnergyW - 1)) state_nxt = ST_ROOT;
      ST_ROOT: if (step_r == 6'd15) state_nxt = ST_RMS;
      ST_RMS:  state_nxt = ST_OUT;
      ST_OUT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      env_alpha_r <= EnvAlphaRst;
      rms_alpha_r <= RmsAlphaRst;
      env_r       <= '0;
      rms_r       <= '0;
      peak_r      <= '0;
      esum_r      <= '0;
      cnt_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgEnvAlpha: env_alpha_r <= cfg_wdata;
          CfgRmsAlpha: rms_alpha_r <= cfg_wdata;
          default: ;
        endcase
      end
      // raise on a new frame result, drop once the beat is taken
      if (state_r == ST_OUT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          step_r <= '0;
          if (in_acc) begin
            abs_r   <= abs_in;
            last_r  <= in_last_in_frame;
            mcand_r <= mag_in;
            mplr_r  <= mag_in;
            prod_r  <= '0;
            if (abs_in > peak_r) peak_r <= abs_in;
            cnt_r   <= cnt_r + 1'b1;
          end
        end
        // add one shifted partial product per cycle
        ST_SQR: begin
          if (mplr_r[0]) prod_r <= prod_r + ({16'b0, mcand_r} << step_r[3:0]);
          mplr_r <= mplr_r >> 1;
          step_r <= (step_r == 6'd15) ? '0 : step_r + 1'b1;
        end
        // advance the envelope and accumulate the frame energy
        ST_ENV: begin
          env_r  <= one_pole(env_r, abs_r, env_alpha_r);
          esum_r <= esum_r + EnergyW'(prod_r);
        end
        // restoring divide, one quotient bit per cycle; load the root at the end
        ST_DIV: begin
          step_r <= (step_r == 6'(EnergyW - 1)) ? '0 : step_r + 1'b1;
          if (step_r == 6'(EnergyW - 1)) begin
            mean_r <= mean_nxt;
            rx_r   <= {1'b0, mean_nxt};
            rrem_r <= '0;
            root_r <= '0;
          end
        end
        // restoring root, two radicand bits per cycle
        ST_ROOT: begin
          if (!rtrial[17]) begin
            rrem_r <= rtrial;
            root_r <= {root_r[14:0], 1'b1};
          end else begin
            rrem_r <= {rrem_r[15:0], rx_r[31:30]};
            root_r <= {root_r[14:0], 1'b0};
          end
          rx_r   <= rx_r << 2;
          step_r <= (step_r == 6'd15) ? '0 : step_r + 1'b1;
        end
        ST_RMS: rms_r <= one_pole(rms_r, root_sat[14:0], rms_alpha_r);
        ST_OUT: begin
          if (out_free) begin
            o_peak_r    <= peak_r;
            o_env_r     <= env_r;
            o_rms_r     <= rms_r;
            o_mean_r    <= mean_r;
            peak_r      <= '0;
            esum_r      <= '0;
            cnt_r       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_DIV) begin
      drem_r <= div_ge ? dsh - cnt_ext : dsh;
      dq_r   <= {dq_cur[EnergyW-2:0], div_ge};
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_peak     = o_peak_r;
  assign out_envelope_level = o_env_r;
  assign out_smoothed_rms   = o_rms_r;
  assign out_mean_energy    = o_mean_r;

endmodule

// ----- tb/tb_audio_level_detector.sv -----
module tb_audio_level_detector;
  import ald_pkg::*;

  // Mirror of the level detector: per-sample peak/energy/envelope,
  // per-frame mean, root and smoothed RMS.
  class level_scoreboard;
    typedef struct packed {
      logic [14:0] peak;
      logic [14:0] env;
      logic [14:0] rms;
      logic [30:0] mean;
    } frame_level_t;

    int unsigned env_alpha;
    int unsigned rms_alpha;
    int envelope;
    int rms_level;
    int peak;
    longint unsigned energy;
    int unsigned count;
    int unsigned max_frame;
    frame_level_t expected_levels[$];
    int mismatches;

    function new(int unsigned frame_cap);
      max_frame = frame_cap;
      env_alpha = EnvAlphaRst;
      rms_alpha = RmsAlphaRst;
      envelope = 0;
      rms_level = 0;
      peak = 0;
      energy = 0;
      count = 0;
      mismatches = 0;
    endfunction

    // One-pole step with floor rounding, clamped to the Q15 range
    function int one_pole_step(int y, int target, int unsigned alpha);
      longint p;
      int v;
      p = longint'(alpha) * longint'(target - y);
      v = y + int'(p >>> 15);
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      return v;
    endfunction

    // Bitwise integer square root, saturated to 32767
    function int isqrt_sat(longint unsigned x);
      longint unsigned bitv;
      longint unsigned root;
      bitv = 64'h4000_0000_0000_0000;
      root = 0;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (x >= root + bitv) begin
          x = x - (root + bitv);
          root = (root >> 1) + bitv;
        end else begin
          root = root >> 1;
        end
        bitv = bitv >> 2;
      end
      return (root > 32767) ? 32767 : int'(root);
    endfunction

    function void note_sample(logic signed [15:0] s, logic last);
      int x;
      int a;
      longint unsigned mean;
      frame_level_t lv;
      x = s;
      a = (x == -32768) ? 32767 : ((x < 0) ? -x : x);
      if (a > peak) peak = a;
      energy += longint'(x) * longint'(x);
      envelope = one_pole_step(envelope, a, env_alpha);
      count++;
      if (!last && count < max_frame) return;
      mean = energy / count;
      rms_level = one_pole_step(rms_level, isqrt_sat(mean), rms_alpha);
      lv.peak = peak[14:0];
      lv.env = envelope[14:0];
      lv.rms = rms_level[14:0];
      lv.mean = mean[30:0];
      expected_levels.push_back(lv);
      peak = 0;
      energy = 0;
      count = 0;
    endfunction

    function void check_result(logic [14:0] pk, logic [14:0] ev, logic [14:0] rm,
                               logic [30:0] mn);
      frame_level_t lv;
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: peak=%0d env=%0d rms=%0d mean=%0d",
                   pk, ev, rm, mn);
        return;
      end
      lv = expected_levels.pop_front();
      if (lv.peak !== pk || lv.env !== ev || lv.rms !== rm || lv.mean !== mn) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp peak=%0d env=%0d rms=%0d mean=%0d,",
                   lv.peak, lv.env, lv.rms, lv.mean,
                   " got peak=%0d env=%0d rms=%0d mean=%0d", pk, ev, rm, mn);
      end
    endfunction
  endclass

  localparam int unsigned FrameCap = 1024;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned HoldCycles = 1500;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [14:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] in_sample;
  logic in_last_in_frame;
  logic out_valid;
  logic out_stall;
  logic [14:0] out_frame_peak;
  logic [14:0] out_envelope_level;
  logic [14:0] out_smoothed_rms;
  logic [30:0] out_mean_energy;

  level_scoreboard levels;
  int unsigned idle_cycles;
  bit hold_req;

  audio_level_detector #(.MAX_FRAME(FrameCap)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .in_last_in_frame(in_last_in_frame),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_frame_peak(out_frame_peak), .out_envelope_level(out_envelope_level),
    .out_smoothed_rms(out_smoothed_rms), .out_mean_energy(out_mean_energy)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Observe both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) levels.note_sample(in_sample, in_last_in_frame);
      if (out_valid && !out_stall)
        levels.check_result(out_frame_peak, out_envelope_level, out_smoothed_rms,
                            out_mean_energy);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: random stall runs, plus one long hold-off on request
  initial begin
    int unsigned run;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else begin
        run = gap_len();
        out_stall = (run != 0);
        repeat (run) @(negedge clk);
        out_stall = 1'b0;
        repeat ($urandom_range(0, 40)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(logic idx, logic [14:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CfgEnvAlpha) levels.env_alpha = val;
    else levels.rms_alpha = val;
  endtask

  // Offer one beat and hold it until taken, then drop valid and maybe pause
  task automatic send_beat(logic signed [15:0] s, logic last, bit allow_gap);
    int unsigned g;
    in_valid = 1'b1;
    in_sample = s;
    in_last_in_frame = last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    in_valid = 1'b0;
    g = allow_gap ? gap_len() : 0;
    repeat (g) @(negedge clk);
  endtask

  // Wait for every pending frame result, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (levels.expected_levels.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_sample();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 16'sh8000;
    if (r < 12) return 16'sh7FFF;
    if (r < 16) return 16'sh0000;
    if (r < 20) return 16'shFFFF;
    if (r < 40) return 16'($urandom_range(0, 255) - 128);
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic random_frames(int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) len = $urandom_range(1, 8);
      else if (r < 97) len = $urandom_range(9, 40);
      else len = $urandom_range(41, 120);
      for (int unsigned k = 1; k <= len; k++)
        send_beat(rand_sample(), k == len, 1'b1);
      sent += len;
    end
  endtask

  initial begin
    levels = new(FrameCap);
    idle_cycles = 0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CfgEnvAlpha;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_sample = '0;
    in_last_in_frame = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, single-sample frames, full-scale negative frame
    send_beat(16'sh8000, 1'b1, 1'b0);
    send_beat(16'sh7FFF, 1'b1, 1'b0);
    send_beat(16'sh0000, 1'b1, 1'b0);
    send_beat(16'shFFFF, 1'b0, 1'b0);
    send_beat(16'sh0001, 1'b1, 1'b0);
    for (int k = 0; k < 4; k++) send_beat(16'sh8000, k == 3, 1'b0);
    send_beat(16'sh8001, 1'b0, 1'b1);
    send_beat(16'sh5555, 1'b0, 1'b1);
    send_beat(16'shAAAA, 1'b1, 1'b1);
    drain();

    // Extreme coefficients: fastest followers
    write_reg(CfgEnvAlpha, 15'h7FFF);
    write_reg(CfgRmsAlpha, 15'h7FFF);
    send_beat(16'sh8000, 1'b1, 1'b0);
    send_beat(16'sh0000, 1'b1, 1'b0);
    random_frames(250);
    drain();

    // Frozen followers
    write_reg(CfgEnvAlpha, 15'h0000);
    write_reg(CfgRmsAlpha, 15'h0000);
    random_frames(100);
    drain();

    // Random coefficients, receiver holds off while samples keep coming
    write_reg(CfgEnvAlpha, 15'($urandom_range(0, 32767)));
    write_reg(CfgRmsAlpha, 15'($urandom_range(0, 32767)));
    hold_req = 1'b1;
    random_frames(150);
    while (hold_req) @(negedge clk);
    drain();

    // Forced frame end: one run past the frame cap
    write_reg(CfgEnvAlpha, 15'($urandom_range(1, 32767)));
    write_reg(CfgRmsAlpha, 15'($urandom_range(1, 32767)));
    for (int unsigned k = 1; k <= FrameCap + 5; k++)
      send_beat(rand_sample(), k == FrameCap + 5, k > FrameCap - 8);
    drain();

    write_reg(CfgEnvAlpha, 15'd1);
    write_reg(CfgRmsAlpha, 15'h7FFE);
    random_frames(150);
    drain();

    if (levels.mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/ald_pkg.sv
rtl/audio_level_detector.sv
tb/tb_audio_level_detector.sv
